// ----- rtl/core/first_fit_free_list_allocator_defines.svh -----
// assertion macros for the first-fit allocator
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
// concurrent check on a clock with synchronous active-low reset
`define FFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/core/ffa_pkg.sv -----
// types, constants and command/status structs for the first-fit allocator
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int MaxRegions = 16;
  localparam int AddrBits   = 24;
  localparam int SizeBits   = AddrBits + 1;
  localparam int IdxBits    = $clog2(MaxRegions);
  localparam int CntBits    = $clog2(MaxRegions + 1);
  localparam logic [SizeBits-1:0] PoolLimit = SizeBits'(1) << AddrBits;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic                req_type;
    logic [SizeBits-1:0] req_size;
    logic [AddrBits-1:0] buf_addr;
    logic [SizeBits-1:0] buf_size;
    logic [SizeBits-1:0] return_amount;
  } ffa_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [AddrBits-1:0] grant_addr;
    logic [SizeBits-1:0] grant_size;
    logic [SizeBits-1:0] free_bytes;
    logic [SizeBits-1:0] allocated_bytes;
  } ffa_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, prepare return span
    logic init;     // reinitialize pool from config
    logic scan;     // examine entry at cursor
    logic apply;    // apply decision at found position
    logic shift;    // move one entry during insert or remove
    logic finish;   // drive result
  } ffa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // cursor reached the stopping entry or the end
    logic shift_done;  // no further entries to move
    logic early;       // result known without a walk
  } ffa_sts_t;

  function automatic logic [SizeBits-1:0] sat_size(input logic [SizeBits:0] v);
    sat_size = (v > {1'b0, PoolLimit}) ? PoolLimit : v[SizeBits-1:0];
  endfunction
endpackage

// ----- rtl/core/ffa_ctrl.sv -----
// controller state machine for the first-fit allocator
`timescale 1ns / 1ps
`include "first_fit_free_list_allocator_defines.svh"
module ffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            cfg_fire,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd,
  output logic            busy
);
  import ffa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_APPLY, S_SHIFT, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = sts.early ? S_DONE : S_SCAN;
      S_SCAN:  if (sts.scan_done) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_SHIFT;
      S_SHIFT: if (sts.shift_done) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.init   = cfg_fire;
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.scan   = (state_r == S_SCAN);
    cmd.apply  = (state_r == S_APPLY);
    cmd.shift  = (state_r == S_SHIFT);
    cmd.finish = (state_r == S_DONE);
  end
  assign busy = (state_r != S_IDLE);

  `FFA_ASSERT(a_start_leaves_idle, clk, rst_n, (state_r == S_IDLE && start) |=> state_r == S_LOAD, "start not taken")
  `FFA_ASSERT(a_done_one_cycle, clk, rst_n, cmd.finish |=> !cmd.finish, "result longer than one cycle")
  `FFA_ASSERT(a_apply_then_shift, clk, rst_n, cmd.apply |=> cmd.shift, "apply not followed by shift")
endmodule

// ----- rtl/core/ffa_dp.sv -----
// datapath: free list registers, walk cursor, totals and result
`timescale 1ns / 1ps
`include "first_fit_free_list_allocator_defines.svh"
module ffa_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::ffa_cmd_t cmd,
  input  ffa_pkg::ffa_in_t  in_req,
  input  logic [ffa_pkg::SizeBits-1:0] cfg_data,
  output ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_out_t out_res,
  output logic              out_valid
);
  import ffa_pkg::*;

  // list kept in flip-flops; entries beyond the count are never read
  logic [AddrBits-1:0] rstart_r [MaxRegions];
  logic [SizeBits-1:0] rsize_r  [MaxRegions];
  logic [CntBits-1:0]  count_r;
  logic [SizeBits-1:0] alloc_r, pool_r;

  logic                typ_r;
  logic [SizeBits-1:0] want_r, rsz_r;
  logic [SizeBits:0]   rs_r;      // return start, extra bit
  logic [SizeBits:0]   rend_r;
  logic [CntBits-1:0]  pos_r;
  logic [1:0]          status_r;
  logic [AddrBits-1:0] gaddr_r;
  logic [SizeBits-1:0] gsize_r;
  logic                remove_r, insert_r;
  logic [CntBits-1:0]  sh_r;     // shift cursor
  logic                valid_r;

  // return span preparation
  logic [SizeBits:0] ba_w, bs_w, amt_w, rs_w, rsz_w, rsz_c;
  always_comb begin
    ba_w  = {2'b0, in_req.buf_addr};
    bs_w  = {1'b0, in_req.buf_size};
    amt_w = {1'b0, in_req.return_amount};
    if (amt_w == '0 || amt_w >= bs_w) begin
      rs_w = ba_w; rsz_w = bs_w;
    end else begin
      rs_w = ba_w + bs_w - amt_w; rsz_w = amt_w;
    end
    if (rs_w >= {1'b0, pool_r}) rsz_c = '0;
    else if (rsz_w > {1'b0, pool_r} - rs_w) rsz_c = {1'b0, pool_r} - rs_w;
    else rsz_c = rsz_w;
  end

  logic [SizeBits-1:0] avail_w;
  assign avail_w = (alloc_r > pool_r) ? '0 : pool_r - alloc_r;

  // entry at cursor
  logic [IdxBits-1:0]  pidx;
  logic [IdxBits-1:0]  pidx_m1;
  logic                at_end;
  assign pidx    = pos_r[IdxBits-1:0];
  assign pidx_m1 = pidx - 1'b1;
  assign at_end  = (pos_r >= count_r);
  logic hit_w;
  assign hit_w = typ_r ? ({2'b0, rstart_r[pidx]} >= rend_r)
                       : (rsize_r[pidx] >= want_r);

  // merge decision at found position
  logic mp_w, mn_w;
  logic [SizeBits:0] prev_end;
  assign prev_end = {2'b0, rstart_r[pidx_m1]} + {1'b0, rsize_r[pidx_m1]};
  assign mp_w = (pos_r != '0) && prev_end == rs_r;
  assign mn_w = !at_end && {2'b0, rstart_r[pidx]} == rend_r;

  logic [IdxBits-1:0] shi, shi_m1, shi_p1;
  assign shi    = sh_r[IdxBits-1:0];
  assign shi_m1 = shi - 1'b1;
  assign shi_p1 = shi + 1'b1;

  assign sts.early      = typ_r ? (rsz_r == '0) : (avail_w < want_r);
  assign sts.scan_done  = at_end || hit_w;
  assign sts.shift_done = remove_r ? ({1'b0, sh_r} + 1'b1 >= {1'b0, count_r})
                        : insert_r ? (sh_r <= pos_r) : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CntBits'(1);
      alloc_r     <= '0;
      pool_r      <= PoolLimit;
      rstart_r[0] <= '0;
      rsize_r[0]  <= PoolLimit;
      valid_r     <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
      if (cmd.init) begin
        pool_r      <= sat_size({1'b0, cfg_data});
        rstart_r[0] <= '0;
        rsize_r[0]  <= sat_size({1'b0, cfg_data});
        count_r     <= (cfg_data != '0) ? CntBits'(1) : '0;
        alloc_r     <= '0;
      end
      if (cmd.load) begin
        typ_r    <= in_req.req_type;
        want_r   <= in_req.req_size;
        rs_r     <= rs_w;
        rsz_r    <= rsz_c[SizeBits-1:0];
        rend_r   <= rs_w + rsz_c;
        pos_r    <= '0;
        remove_r <= 1'b0;
        insert_r <= 1'b0;
        gaddr_r  <= '0;
        gsize_r  <= '0;
        status_r <= in_req.req_type ? ST_OK
                  : ((avail_w < in_req.req_size) ? ST_NOSPACE : ST_OK);
      end
      if (cmd.scan && !sts.scan_done) pos_r <= pos_r + 1'b1;
      if (cmd.apply) begin
        if (!typ_r) begin
          if (at_end) begin
            status_r <= ST_NOFIT;
          end else begin
            gaddr_r <= rstart_r[pidx];
            gsize_r <= want_r;
            alloc_r <= sat_size({1'b0, alloc_r} + {1'b0, want_r});
            if (rsize_r[pidx] == want_r) begin
              remove_r <= 1'b1;
              sh_r     <= pos_r;
            end else begin
              rstart_r[pidx] <= rstart_r[pidx] + want_r[AddrBits-1:0];
              rsize_r[pidx]  <= rsize_r[pidx] - want_r;
            end
          end
        end else begin
          if (mp_w && mn_w) begin
            rsize_r[pidx_m1] <= sat_size({1'b0, rsize_r[pidx_m1]} + {1'b0, rsz_r}
                                         + {1'b0, rsize_r[pidx]});
            remove_r <= 1'b1;
            sh_r     <= pos_r;
          end else if (mp_w) begin
            rsize_r[pidx_m1] <= sat_size({1'b0, rsize_r[pidx_m1]} + {1'b0, rsz_r});
          end else if (mn_w) begin
            rstart_r[pidx] <= rs_r[AddrBits-1:0];
            rsize_r[pidx]  <= sat_size({1'b0, rsize_r[pidx]} + {1'b0, rsz_r});
          end else if (count_r >= CntBits'(MaxRegions)) begin
            status_r <= ST_FULL;
          end else begin
            insert_r <= 1'b1;
            sh_r     <= count_r;
          end
          if (mp_w || mn_w || count_r < CntBits'(MaxRegions)) begin
            gsize_r <= rsz_r;
            alloc_r <= (alloc_r > rsz_r) ? alloc_r - rsz_r : '0;
          end
        end
      end
      if (cmd.shift) begin
        if (remove_r) begin
          if ({1'b0, sh_r} + 1'b1 < {1'b0, count_r}) begin
            rstart_r[shi] <= rstart_r[shi_p1];
            rsize_r[shi]  <= rsize_r[shi_p1];
            sh_r          <= sh_r + 1'b1;
          end else begin
            count_r  <= count_r - 1'b1;
            remove_r <= 1'b0;
          end
        end else if (insert_r) begin
          if (sh_r > pos_r) begin
            rstart_r[shi] <= rstart_r[shi_m1];
            rsize_r[shi]  <= rsize_r[shi_m1];
            sh_r          <= sh_r - 1'b1;
          end else begin
            rstart_r[shi] <= rs_r[AddrBits-1:0];
            rsize_r[shi]  <= rsz_r;
            count_r       <= count_r + 1'b1;
            insert_r      <= 1'b0;
          end
        end
      end
    end
  end

  assign out_valid = valid_r;
  always_comb begin
    out_res.status          = status_r;
    out_res.grant_addr      = gaddr_r;
    out_res.grant_size      = gsize_r;
    out_res.free_bytes      = avail_w;
    out_res.allocated_bytes = alloc_r;
  end

  `FFA_ASSERT(a_count_bound, clk, rst_n, count_r <= CntBits'(MaxRegions), "free list overflow")
  `FFA_ASSERT(a_one_op, clk, rst_n, !(remove_r && insert_r), "insert and remove together")
  `FFA_ASSERT(a_fail_no_grant, clk, rst_n, (valid_r && status_r != ST_OK) |-> gsize_r == '0, "grant on failure")
endmodule

// ----- rtl/core/first_fit_free_list_allocator.sv -----
// top level of the first-fit free list allocator
// a request passes the load, list walk, apply, entry shift and done states before its result
// a no-space allocation or an empty return goes from load straight to done
// one request at a time, the next start is taken in the result cycle; results cannot stall
// reset (synchronous, rst_n low): one free region covering the whole pool, nothing allocated
`timescale 1ns / 1ps
module first_fit_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  ffa_pkg::ffa_in_t             in_data,
  output logic                         out_valid,
  output ffa_pkg::ffa_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffa_pkg::SizeBits-1:0] cfg_data
);
  import ffa_pkg::*;

  ffa_cmd_t cmd;
  ffa_sts_t sts;
  logic     cfg_fire;

  assign cfg_ready = !busy && !start;
  assign cfg_fire  = cfg_valid && cfg_ready;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg_fire (cfg_fire),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  ffa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_data),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_res   (out_data),
    .out_valid (out_valid)
  );
endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the first-fit free list allocator
`timescale 1ns / 1ps
module testbench;
  import ffa_pkg::*;

  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_RETURN = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ffa_in_t in_data = '0;
  logic out_valid;
  ffa_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SizeBits-1:0] cfg_data = '0;

  first_fit_free_list_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [AddrBits-1:0] fr_start [MaxRegions];
  logic [SizeBits-1:0] fr_size [MaxRegions];
  int unsigned fr_count;
  logic [SizeBits-1:0] alloc_sum;
  logic [SizeBits-1:0] pool_size;

  ffa_in_t pending_reqs[$];
  ffa_out_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int n_full = 0, n_nofit = 0, n_nospace = 0;
  int gap = 0;
  bit quiet = 0;

  // bookkeeping of granted regions for well-formed returns
  logic [AddrBits-1:0] held_addr[$];
  logic [SizeBits-1:0] held_size[$];

  function automatic logic [SizeBits-1:0] clip_size(longint unsigned v);
    return (v > longint'(PoolLimit)) ? PoolLimit : v[SizeBits-1:0];
  endfunction

  function automatic void pool_reinit(logic [SizeBits-1:0] total);
    pool_size = clip_size(64'(total));
    for (int k = 0; k < MaxRegions; k++) begin
      fr_start[k] = '0;
      fr_size[k] = '0;
    end
    fr_size[0] = pool_size;
    fr_count = (pool_size != 0) ? 1 : 0;
    alloc_sum = '0;
  endfunction

  function automatic void remove_region(int unsigned pos);
    for (int unsigned k = pos; k + 1 < fr_count; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_size[k] = fr_size[k+1];
    end
    fr_count--;
  endfunction

  function automatic ffa_out_t predict_allocator(ffa_in_t req);
    ffa_out_t r;
    longint unsigned want, avail, ba, bs, amt, rs, rsz, rend, total;
    int unsigned pos;
    bit mp, mn, found;
    r = '0;
    total = 64'(pool_size);
    if (req.req_type == REQ_ALLOC) begin
      want = 64'(req.req_size);
      avail = (alloc_sum > pool_size) ? 0 : total - 64'(alloc_sum);
      if (avail < want) r.status = ST_NOSPACE;
      else begin
        found = 0;
        for (int unsigned k = 0; k < fr_count && !found; k++) begin
          if (fr_size[k] >= want) begin
            found = 1;
            r.grant_addr = fr_start[k];
            if (fr_size[k] == want) remove_region(k);
            else begin
              fr_start[k] = fr_start[k] + want[AddrBits-1:0];
              fr_size[k] = fr_size[k] - want[SizeBits-1:0];
            end
            alloc_sum = clip_size(longint'(alloc_sum) + want);
          end
        end
        if (found) r.grant_size = want[SizeBits-1:0];
        else r.status = ST_NOFIT;
      end
    end else begin
      ba = 64'(req.buf_addr);
      bs = 64'(req.buf_size);
      amt = 64'(req.return_amount);
      if (amt == 0 || amt >= bs) begin
        rs = ba;
        rsz = bs;
      end else begin
        rs = ba + bs - amt;
        rsz = amt;
      end
      if (rs >= total) rsz = 0;
      else if (rsz > total - rs) rsz = total - rs;
      r.status = ST_OK;
      if (rsz != 0) begin
        rend = rs + rsz;
        pos = 0;
        while (pos < fr_count && fr_start[pos] < rend) pos++;
        mp = pos > 0 && longint'(fr_start[pos-1]) + fr_size[pos-1] == rs;
        mn = pos < fr_count && fr_start[pos] == rend;
        if (mp && mn) begin
          fr_size[pos-1] = clip_size(longint'(fr_size[pos-1]) + rsz + fr_size[pos]);
          remove_region(pos);
        end else if (mp) begin
          fr_size[pos-1] = clip_size(longint'(fr_size[pos-1]) + rsz);
        end else if (mn) begin
          fr_start[pos] = rs[AddrBits-1:0];
          fr_size[pos] = clip_size(longint'(fr_size[pos]) + rsz);
        end else if (fr_count >= MaxRegions) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned k = fr_count; k > pos; k--) begin
            fr_start[k] = fr_start[k-1];
            fr_size[k] = fr_size[k-1];
          end
          fr_start[pos] = rs[AddrBits-1:0];
          fr_size[pos] = rsz[SizeBits-1:0];
          fr_count++;
        end
        if (r.status == ST_OK) begin
          alloc_sum = (alloc_sum > rsz) ? alloc_sum - rsz[SizeBits-1:0] : '0;
          r.grant_size = rsz[SizeBits-1:0];
        end
      end
    end
    r.free_bytes = (alloc_sum > pool_size) ? '0 : pool_size - alloc_sum;
    r.allocated_bytes = alloc_sum;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(predict_allocator(in_data));
        sent++;
      end
      if (start && busy) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        gap <= int'($urandom_range(1, 18));
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ffa_out_t exp_r;
    if (rst_n && out_valid) begin
      received++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.status == ST_FULL) n_full++;
        if (exp_r.status == ST_NOFIT) n_nofit++;
        if (exp_r.status == ST_NOSPACE) n_nospace++;
        if (out_data.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_data.status);
        if (out_data.grant_addr !== exp_r.grant_addr)
          $display("%0t: grant_addr exp %h got %h", $time, exp_r.grant_addr,
                   out_data.grant_addr);
        if (out_data.grant_size !== exp_r.grant_size)
          $display("%0t: grant_size exp %h got %h", $time, exp_r.grant_size,
                   out_data.grant_size);
        if (out_data.free_bytes !== exp_r.free_bytes)
          $display("%0t: free_bytes exp %h got %h", $time, exp_r.free_bytes,
                   out_data.free_bytes);
        if (out_data.allocated_bytes !== exp_r.allocated_bytes)
          $display("%0t: allocated_bytes exp %h got %h", $time, exp_r.allocated_bytes,
                   out_data.allocated_bytes);
        if (out_data !== exp_r) errors++;
      end
    end
  end

  task automatic write_pool(input logic [SizeBits-1:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_reinit(value);
    held_addr.delete();
    held_size.delete();
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic ffa_in_t make_alloc(logic [SizeBits-1:0] sz);
    ffa_in_t r;
    r = '0;
    r.req_type = REQ_ALLOC;
    r.req_size = sz;
    r.buf_addr = AddrBits'($urandom());
    r.buf_size = SizeBits'($urandom());
    r.return_amount = SizeBits'($urandom());
    return r;
  endfunction

  function automatic ffa_in_t make_return(logic [AddrBits-1:0] a, logic [SizeBits-1:0] s,
                                          logic [SizeBits-1:0] amt);
    ffa_in_t r;
    r.req_type = REQ_RETURN;
    r.req_size = SizeBits'($urandom());
    r.buf_addr = a;
    r.buf_size = s;
    r.return_amount = amt;
    return r;
  endfunction

  // shadow of the pool as seen by stimulus, tracks grants approximately
  function automatic ffa_in_t random_request(logic [SizeBits-1:0] total);
    ffa_in_t r;
    int idx;
    int unsigned pick;
    logic [SizeBits-1:0] sz, amt;
    logic [AddrBits-1:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      sz = (total < 8) ? SizeBits'($urandom_range(0, 8))
                       : SizeBits'($urandom_range(0, 32'(total / 6)));
      r = make_alloc(sz);
      if (sz != 0) begin
        held_addr.push_back('0);
        held_size.push_back(sz);
      end
    end else if (pick < 85 && held_size.size() > 0) begin
      idx = int'($urandom_range(0, held_size.size() - 1));
      a = held_addr[idx];
      sz = held_size[idx];
      amt = ($urandom_range(0, 2) == 0) ? '0 : SizeBits'($urandom_range(0, 32'(sz)));
      r = make_return(a, sz, amt);
      held_addr.delete(idx);
      held_size.delete(idx);
    end else if (pick < 92) begin
      r = make_return(AddrBits'($urandom()), SizeBits'($urandom()), SizeBits'($urandom()));
      r.buf_size[SizeBits-1] = 1'($urandom_range(0, 1));
      r.return_amount[SizeBits-1] = 1'($urandom_range(0, 1));
    end else begin
      r = make_alloc(SizeBits'($urandom()));
      r.req_size[SizeBits-1] = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // regions granted so far are learned from the results of the design
  always @(posedge clk) begin
    if (rst_n && out_valid && out_data.grant_size != 0 && out_data.status == ST_OK) begin
      for (int k = 0; k < held_size.size(); k++) begin
        if (held_addr[k] == '0 && held_size[k] == out_data.grant_size) begin
          held_addr[k] = out_data.grant_addr;
          break;
        end
      end
    end
  end

  initial begin
    logic [SizeBits-1:0] totals[4];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pool_reinit(PoolLimit);

    // directed: reset pool, extremes and special cases
    pending_reqs.push_back(make_alloc('0));
    pending_reqs.push_back(make_alloc(PoolLimit + 25'd1));
    pending_reqs.push_back(make_alloc(25'h100));
    pending_reqs.push_back(make_alloc(25'h200));
    pending_reqs.push_back(make_alloc(25'h100));
    pending_reqs.push_back(make_return(24'h100, 25'h200, 25'h0));
    pending_reqs.push_back(make_alloc(25'h300));
    pending_reqs.push_back(make_return(24'h100, 25'h200, 25'h80));
    pending_reqs.push_back(make_return(24'h0, 25'h100, 25'h100));
    pending_reqs.push_back(make_return(24'h300, 25'h400, 25'h400));
    pending_reqs.push_back(make_return(24'hFFFFFF, 25'h1FFFFFF, 25'h0));
    pending_reqs.push_back(make_return(24'h0, 25'h1FFFFFF, 25'h1FFFFFF));
    pending_reqs.push_back(make_alloc(PoolLimit));
    pending_reqs.push_back(make_alloc(25'h1));
    pending_reqs.push_back(make_return(24'h0, PoolLimit, 25'h0));
    wait_drained();

    // fragment a small pool to fill the list, then overflow and no-fit
    write_pool(25'd64);
    repeat (32) pending_reqs.push_back(make_alloc(25'd2));
    for (int k = 0; k < 16; k++)
      pending_reqs.push_back(make_return(24'(4 * k), 25'd1, 25'd0));
    pending_reqs.push_back(make_return(24'd2, 25'd1, 25'd0));
    pending_reqs.push_back(make_alloc(25'd3));
    pending_reqs.push_back(make_return(24'd62, 25'd8, 25'd0));
    wait_drained();

    write_pool('0);
    pending_reqs.push_back(make_alloc('0));
    pending_reqs.push_back(make_alloc(25'd1));
    pending_reqs.push_back(make_return(24'd0, 25'd4, 25'd0));
    wait_drained();

    write_pool(25'h1FFFFFF);
    pending_reqs.push_back(make_alloc(PoolLimit));
    wait_drained();

    totals[0] = 25'd100;
    totals[1] = 25'd4096;
    totals[2] = PoolLimit;
    totals[3] = 25'd1;
    for (int phase = 0; phase < 8; phase++) begin
      write_pool(phase == 7 ? PoolLimit : totals[phase % 4]);
      if (phase == 7) quiet = 1;
      for (int n = 0; n < 150; n++)
        pending_reqs.push_back(random_request(pool_size));
      wait_drained();
    end

    $display("%0d requests sent, %0d results checked over several pool sizes", sent, received);
    $display("no-space %0d, no-fit %0d, list-full %0d", n_nospace, n_nofit, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ffa_pkg.sv
rtl/core/ffa_ctrl.sv
rtl/core/ffa_dp.sv
rtl/core/first_fit_free_list_allocator.sv
tb/sv/testbench.sv
